FILE: rtl/core/jps_pkg.sv
// jps_pkg: types, constants and arithmetic helpers for the jacobi poisson stencil solver
// no dependencies; used by every module in rtl/core
package jps_pkg;

  localparam int GridRows = 64;
  localparam int GridCols = 64;
  localparam int RowBits = 6;
  localparam int ColBits = 6;
  localparam int AddrBits = RowBits + ColBits;
  localparam int Cells = GridRows * GridCols;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_SOLVE = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [2:0] REG_ROWS = 3'd0;
  localparam logic [2:0] REG_COLS = 3'd1;
  localparam logic [2:0] REG_COEF_X = 3'd2;
  localparam logic [2:0] REG_COEF_Y = 3'd3;
  localparam logic [2:0] REG_COEF_RHO = 3'd4;
  localparam logic [2:0] REG_SWEEP_LIMIT = 3'd5;
  localparam logic [2:0] REG_TOL = 3'd6;

  typedef struct packed {
    logic [1:0] command;
    logic [5:0] row;
    logic [5:0] col;
    logic signed [31:0] potential_in;
    logic signed [31:0] source_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] potential_out;
    logic converged;
    logic [15:0] sweeps_done;
    logic [30:0] max_change;
    logic index_error;
  } out_item_t;

  typedef struct packed {
    logic [6:0] rows;
    logic [6:0] cols;
    logic [31:0] coef_x;
    logic [31:0] coef_y;
    logic [31:0] coef_rho;
    logic [15:0] sweep_limit;
    logic [30:0] tol;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP_INIT,
    ST_CELL,
    ST_DRAIN,
    ST_SWEEP_END,
    ST_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;         // write one cell (both banks + source)
    logic read;         // read one cell of current bank
    logic cell_go;      // launch a stencil evaluation at cell_row/cell_col
    logic [5:0] cell_row;
    logic [5:0] cell_col;
    logic sweep_clr;    // clear sweep max change
    logic swap;         // flip current bank
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;          // stencil pipeline still holds work
    logic [30:0] worst;  // max change of the sweep so far
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    if (v < lo) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

FILE: rtl/core/jacobi_poisson_stencil_solver.sv
// jacobi_poisson_stencil_solver: top level, apb register file plus controller and datapath
// depends on jps_pkg, jps_ctrl, jps_datapath
// Load and read commands raise done in the cycle after start is accepted and leave busy low,
// so a new command can follow each cycle. A solve walks the interior cell by cell; each
// cell's operands are read one after another, since the five stencil operands share one
// memory read port and one multiplier, and done follows the last sweep of the solve. busy
// stays high for the whole solve; done marks each result for one cycle and cannot be stalled.
module jacobi_poisson_stencil_solver (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  jps_pkg::in_item_t  in_item,
  output logic               busy,
  output logic               done,
  output jps_pkg::out_item_t out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import jps_pkg::*;

  cfg_t cfg;
  dp_cmd_t cmd;
  dp_stat_t stat;
  logic signed [31:0] rd_data;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign ridx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows <= 7'd64;
      cfg.cols <= 7'd64;
      cfg.coef_x <= '0;
      cfg.coef_y <= '0;
      cfg.coef_rho <= '0;
      cfg.sweep_limit <= 16'd10000;
      cfg.tol <= 31'd17;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_ROWS: cfg.rows <= pwdata[6:0];
        REG_COLS: cfg.cols <= pwdata[6:0];
        REG_COEF_X: cfg.coef_x <= pwdata;
        REG_COEF_Y: cfg.coef_y <= pwdata;
        REG_COEF_RHO: cfg.coef_rho <= pwdata;
        REG_SWEEP_LIMIT: cfg.sweep_limit <= pwdata[15:0];
        REG_TOL: cfg.tol <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_ROWS: prdata = {25'd0, cfg.rows};
      REG_COLS: prdata = {25'd0, cfg.cols};
      REG_COEF_X: prdata = cfg.coef_x;
      REG_COEF_Y: prdata = cfg.coef_y;
      REG_COEF_RHO: prdata = cfg.coef_rho;
      REG_SWEEP_LIMIT: prdata = {16'd0, cfg.sweep_limit};
      REG_TOL: prdata = {1'b0, cfg.tol};
      default: prdata = '0;
    endcase
  end

  jps_ctrl u_ctrl (
    .clk(clk), .rst(rst), .cfg(cfg), .start(start), .item(in_item), .busy(busy),
    .cmd(cmd), .stat(stat), .rd_data(rd_data), .done(done), .result(out_item)
  );

  jps_datapath u_dp (
    .clk(clk), .rst(rst), .cfg(cfg), .cmd(cmd), .item(in_item), .stat(stat),
    .rd_data(rd_data)
  );

endmodule

FILE: rtl/core/jps_datapath.sv
// jps_datapath: cell memories and the five point stencil pipeline
// depends on jps_pkg
module jps_datapath (
  input  logic             clk,
  input  logic             rst,
  input  jps_pkg::cfg_t    cfg,
  input  jps_pkg::dp_cmd_t cmd,
  input  jps_pkg::in_item_t item,
  output jps_pkg::dp_stat_t stat,
  output logic signed [31:0] rd_data
);
  import jps_pkg::*;

  logic signed [31:0] bank_a [Cells];
  logic signed [31:0] bank_b [Cells];
  logic signed [31:0] src_mem [Cells];
  logic cur;

  // stencil issues five reads, one per cycle, from the source bank
  logic [2:0] phase;
  logic active;
  logic [AddrBits-1:0] base;
  logic [AddrBits-1:0] rd_addr;
  logic signed [31:0] rd_src_bank;
  logic signed [31:0] rd_src_term;
  logic signed [31:0] centre;
  logic [2:0] phase_d;
  logic valid_d;
  logic signed [63:0] prod;
  logic [2:0] phase_p;
  logic valid_p;
  logic signed [67:0] acc;
  logic fin;
  logic signed [67:0] acc_fin;
  logic signed [31:0] new_val;
  logic [AddrBits-1:0] wb_addr;
  logic [AddrBits-1:0] base_d;
  logic [AddrBits-1:0] base_p;
  logic signed [31:0] centre_p;
  logic [30:0] worst;
  logic signed [32:0] diff;
  logic [32:0] adiff;
  logic [30:0] chg;
  logic wb_en;
  logic [AddrBits-1:0] ld_addr;

  assign ld_addr = {item.row, item.col};

  always_comb begin
    case (phase)
      3'd0: rd_addr = base - AddrBits'(GridCols);
      3'd1: rd_addr = base + AddrBits'(GridCols);
      3'd2: rd_addr = base - AddrBits'(1);
      3'd3: rd_addr = base + AddrBits'(1);
      default: rd_addr = base;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      phase <= '0;
    end else if (cmd.cell_go) begin
      active <= 1'b1;
      phase <= '0;
      base <= {cmd.cell_row, cmd.cell_col};
    end else if (active) begin
      phase <= phase + 3'd1;
      if (phase == 3'd4) active <= 1'b0;
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bank_a[ld_addr] <= sat32(66'(item.potential_in));
      bank_b[ld_addr] <= sat32(66'(item.potential_in));
      src_mem[ld_addr] <= item.source_in;
    end else if (wb_en) begin
      if (cur) bank_a[wb_addr] <= new_val;
      else bank_b[wb_addr] <= new_val;
    end
  end

  always_ff @(posedge clk) begin
    rd_src_bank <= cur ? bank_b[active ? rd_addr : ld_addr]
                       : bank_a[active ? rd_addr : ld_addr];
    rd_src_term <= src_mem[rd_addr];
    phase_d <= phase;
    base_d <= base;
  end

  assign rd_data = rd_src_bank;

  always_ff @(posedge clk) begin
    if (rst) valid_d <= 1'b0;
    else valid_d <= active;
  end

  // one multiply per cycle, registered
  logic [31:0] coef;
  logic signed [31:0] mval;
  always_comb begin
    case (phase_d)
      3'd0, 3'd1: coef = cfg.coef_x;
      3'd2, 3'd3: coef = cfg.coef_y;
      default: coef = cfg.coef_rho;
    endcase
    mval = (phase_d == 3'd4) ? rd_src_term : rd_src_bank;
  end

  always_ff @(posedge clk) begin
    prod <= mval * $signed({1'b0, coef});
    phase_p <= phase_d;
    base_p <= base_d;
    if (valid_d && phase_d == 3'd4) centre <= rd_src_bank;
    if (rst) valid_p <= 1'b0;
    else valid_p <= valid_d;
  end

  always_ff @(posedge clk) begin
    if (rst) fin <= 1'b0;
    else fin <= valid_p && phase_p == 3'd4;
    if (valid_p) begin
      if (phase_p == 3'd0) acc <= 68'(prod);
      else acc <= acc + 68'(prod);
    end
    if (valid_p && phase_p == 3'd4) begin
      acc_fin <= acc + 68'(prod);
      wb_addr <= base_p;
      centre_p <= centre;
    end
  end

  // round half up then saturate
  logic signed [67:0] rounded;
  assign rounded = (acc_fin + 68'sh80000000) >>> 32;
  assign new_val = sat32(rounded[65:0]);
  assign wb_en = fin;
  assign diff = 33'(new_val) - 33'(centre_p);
  assign adiff = diff[32] ? 33'(-diff) : 33'(diff);
  assign chg = (adiff > 33'h7fffffff) ? 31'h7fffffff : adiff[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= 1'b0;
      worst <= '0;
    end else begin
      if (cmd.swap) cur <= ~cur;
      if (cmd.sweep_clr) worst <= '0;
      else if (fin && chg > worst) worst <= chg;
    end
  end

  assign stat.busy = active | valid_d | valid_p | fin;
  assign stat.worst = worst;

endmodule

FILE: rtl/core/jps_ctrl.sv
// jps_ctrl: command decode, sweep sequencing and solve status
// depends on jps_pkg
module jps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  jps_pkg::cfg_t     cfg,
  input  logic              start,
  input  jps_pkg::in_item_t item,
  output logic              busy,
  output jps_pkg::dp_cmd_t  cmd,
  input  jps_pkg::dp_stat_t stat,
  input  logic signed [31:0] rd_data,
  output logic              done,
  output jps_pkg::out_item_t result
);
  import jps_pkg::*;

  state_t state, state_next;
  logic [6:0] nr, nc;
  logic [5:0] ci, cj;
  logic [15:0] n;
  logic [15:0] last_sweeps;
  logic last_conv;
  logic [30:0] last_chg;
  logic rd_pend, rd_err, rd_is_read, go;
  logic [5:0] ci_next, cj_next;
  logic last_cell, no_interior, in_range;
  logic stop;

  assign nr = (cfg.rows > 7'(GridRows)) ? 7'(GridRows) : cfg.rows;
  assign nc = (cfg.cols > 7'(GridCols)) ? 7'(GridCols) : cfg.cols;
  assign no_interior = (nr < 7'd3) || (nc < 7'd3);
  assign in_range = (7'(item.row) < nr) && (7'(item.col) < nc);
  assign go = start && !busy;
  assign last_cell = (7'(cj) + 7'd2 >= nc) && (7'(ci) + 7'd2 >= nr);
  assign stop = (stat.worst < cfg.tol) || (n + 16'd1 >= cfg.sweep_limit);

  // a counter paces the cell walk; a stencil launches each time it wraps to zero
  logic [2:0] pace;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:
        if (go && item.command == CMD_SOLVE) begin
          state_next = (cfg.sweep_limit == 16'd0) ? ST_RESULT : ST_SWEEP_INIT;
        end
      ST_SWEEP_INIT: state_next = no_interior ? ST_DRAIN : ST_CELL;
      ST_CELL: if (last_cell && pace == 3'd0) state_next = ST_DRAIN;
      ST_DRAIN: if (!stat.busy && !cmd.cell_go) state_next = ST_SWEEP_END;
      ST_SWEEP_END: state_next = stop ? ST_RESULT : ST_SWEEP_INIT;
      ST_RESULT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.cell_row = ci;
    cmd.cell_col = cj;
    cmd.load = go && item.command == CMD_LOAD && in_range;
    cmd.read = go && item.command == CMD_READ;
    cmd.cell_go = (state == ST_CELL) && (pace == 3'd0);
    cmd.sweep_clr = (state == ST_SWEEP_INIT);
    cmd.swap = (state == ST_SWEEP_END);
  end

  always_comb begin
    ci_next = ci;
    cj_next = cj;
    if (7'(cj) + 7'd2 >= nc) begin
      cj_next = 6'd1;
      ci_next = ci + 6'd1;
    end else begin
      cj_next = cj + 6'd1;
    end
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pace <= '0;
      n <= '0;
      last_sweeps <= '0;
      last_conv <= 1'b0;
      last_chg <= '0;
      rd_pend <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      rd_pend <= go && item.command != CMD_SOLVE;
      rd_err <= go && (item.command == CMD_LOAD || item.command == CMD_READ) && !in_range;
      rd_is_read <= go && item.command == CMD_READ && in_range;
      if (go && item.command != CMD_SOLVE) done <= 1'b1;
      case (state)
        ST_IDLE: begin
          n <= '0;
          if (go && item.command == CMD_SOLVE && cfg.sweep_limit == 16'd0) begin
            last_sweeps <= '0;
            last_conv <= 1'b0;
            last_chg <= '0;
          end
        end
        ST_SWEEP_INIT: begin
          ci <= 6'd1;
          cj <= 6'd1;
          pace <= '0;
        end
        ST_CELL: begin
          pace <= (pace == 3'd4) ? 3'd0 : pace + 3'd1;
          if (pace == 3'd0) begin
            ci <= ci_next;
            cj <= cj_next;
          end
        end
        ST_SWEEP_END: begin
          n <= n + 16'd1;
          if (stop) begin
            last_sweeps <= n + 16'd1;
            last_conv <= stat.worst < cfg.tol;
            last_chg <= stat.worst;
          end
        end
        ST_RESULT: done <= 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    result.potential_out = (rd_is_read && state == ST_IDLE) ? rd_data : '0;
    result.converged = last_conv;
    result.sweeps_done = last_sweeps;
    result.max_change = last_chg;
    result.index_error = rd_err && state == ST_IDLE;
  end

  // the last launch must come on a pace boundary before drain
  a_swap_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.swap |-> !stat.busy) else $error("bank swap with stencil busy");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == ST_IDLE) else $error("load during solve");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done || rd_pend) else $error("result strobe stuck");

endmodule

FILE: tb/tb_jacobi_poisson_stencil_solver.sv
// tb_jacobi_poisson_stencil_solver: self-checking testbench for the jacobi poisson stencil solver
// depends on jps_pkg and jacobi_poisson_stencil_solver; a scoreboard class predicts each result
`timescale 1ns / 1ps

module tb_jacobi_poisson_stencil_solver;
  import jps_pkg::*;

  class solver_scoreboard;
    int unsigned rows_cfg, cols_cfg, sweep_limit_cfg;
    bit [31:0] cx, cy, crho;
    bit [30:0] tol_cfg;
    int pot[2][Cells];
    int src[Cells];
    bit cur;
    bit [15:0] last_sweeps;
    bit last_conv;
    bit [30:0] last_change;
    out_item_t status_q[$];
    int fails;

    function new();
      rows_cfg = 64; cols_cfg = 64; cx = 0; cy = 0; crho = 0;
      sweep_limit_cfg = 10000; tol_cfg = 17;
      cur = 0; last_sweeps = 0; last_conv = 0; last_change = 0; fails = 0;
    endfunction

    function void set_reg(logic [2:0] idx, bit [31:0] val);
      case (idx)
        REG_ROWS:        rows_cfg = val[6:0];
        REG_COLS:        cols_cfg = val[6:0];
        REG_COEF_X:      cx = val;
        REG_COEF_Y:      cy = val;
        REG_COEF_RHO:    crho = val;
        REG_SWEEP_LIMIT: sweep_limit_cfg = val[15:0];
        REG_TOL:         tol_cfg = val[30:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_rows();
      return rows_cfg > GridRows ? GridRows : rows_cfg;
    endfunction

    function int unsigned eff_cols();
      return cols_cfg > GridCols ? GridCols : cols_cfg;
    endfunction

    function logic signed [71:0] weigh(int val, bit [31:0] k);
      longint p;
      p = longint'(val) * longint'({32'b0, k});
      return 72'(p);
    endfunction

    // one jacobi sweep from the current bank into the other, returns the largest change
    function bit [30:0] sweep();
      bit [30:0] worst;
      logic signed [71:0] acc;
      longint nv, d;
      int c;
      worst = 0;
      for (int i = 1; i + 1 < eff_rows(); i++) begin
        for (int j = 1; j + 1 < eff_cols(); j++) begin
          c = i * GridCols + j;
          acc = weigh(pot[cur][c - GridCols], cx) + weigh(pot[cur][c + GridCols], cx)
              + weigh(pot[cur][c - 1], cy) + weigh(pot[cur][c + 1], cy)
              + weigh(src[c], crho);
          acc = (acc + 72'sd2147483648) >>> 32;
          if (acc > 72'sd2147483647) nv = 64'sd2147483647;
          else if (acc < -72'sd2147483648) nv = -64'sd2147483648;
          else nv = longint'(acc);
          pot[!cur][c] = int'(nv);
          d = nv - longint'(pot[cur][c]);
          if (d < 0) d = -d;
          if (d > 64'h7fffffff) d = 64'h7fffffff;
          if (d[30:0] > worst) worst = d[30:0];
        end
      end
      return worst;
    endfunction

    function void note(in_item_t it);
      out_item_t r;
      int unsigned n;
      bit fin;
      bit [30:0] ch;
      int c;
      r = '0;
      if (it.command == CMD_SOLVE) begin
        n = 0; fin = 0; ch = 0;
        while (n < sweep_limit_cfg && !fin) begin
          ch = sweep();
          cur = !cur;
          n++;
          if (ch < tol_cfg) fin = 1;
        end
        last_sweeps = n[15:0]; last_conv = fin; last_change = ch;
      end else if (it.command == CMD_LOAD || it.command == CMD_READ) begin
        if (it.row >= eff_rows() || it.col >= eff_cols()) begin
          r.index_error = 1;
        end else begin
          c = it.row * GridCols + it.col;
          if (it.command == CMD_LOAD) begin
            pot[0][c] = it.potential_in;
            pot[1][c] = it.potential_in;
            src[c] = it.source_in;
          end else begin
            r.potential_out = pot[cur][c];
          end
        end
      end
      r.converged = last_conv;
      r.sweeps_done = last_sweeps;
      r.max_change = last_change;
      status_q.push_back(r);
    endfunction

    function void check(out_item_t got);
      out_item_t exp_r;
      if (status_q.size() == 0) begin
        $error("result with no transaction pending");
        fails++;
        return;
      end
      exp_r = status_q.pop_front();
      if (got.potential_out !== exp_r.potential_out) begin
        $error("potential_out exp %h got %h", exp_r.potential_out, got.potential_out);
        fails++;
      end
      if (got.converged !== exp_r.converged) begin
        $error("converged exp %b got %b", exp_r.converged, got.converged);
        fails++;
      end
      if (got.sweeps_done !== exp_r.sweeps_done) begin
        $error("sweeps_done exp %0d got %0d", exp_r.sweeps_done, got.sweeps_done);
        fails++;
      end
      if (got.max_change !== exp_r.max_change) begin
        $error("max_change exp %h got %h", exp_r.max_change, got.max_change);
        fails++;
      end
      if (got.index_error !== exp_r.index_error) begin
        $error("index_error exp %b got %b", exp_r.index_error, got.index_error);
        fails++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  in_item_t in_item = '0;
  logic busy, done;
  out_item_t out_item;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  solver_scoreboard sb = new();
  bit written[GridRows][GridCols];
  bit no_gaps;

  jacobi_poisson_stencil_solver dut (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item), .busy(busy), .done(done),
    .out_item(out_item), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check(out_item);
  end

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function logic signed [31:0] pick_q824();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3: return $urandom;
      default: return $signed($urandom) >>> $urandom_range(4, 12);
    endcase
  endfunction

  task automatic send(logic [1:0] cmd, int r, int c);
    in_item_t it;
    int g;
    it.command = cmd;
    it.row = r[5:0];
    it.col = c[5:0];
    it.potential_in = pick_q824();
    it.source_in = pick_q824();
    @(negedge clk);
    start <= 1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sb.note(it);
    if (cmd == CMD_LOAD && r < sb.eff_rows() && c < sb.eff_cols()) written[r][c] = 1;
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      start <= 0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 0;
    while (sb.status_q.size() > 0) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, bit [31:0] val);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic configure(int rows, int cols, bit [31:0] kx, bit [31:0] ky, bit [31:0] kr,
                           int maxit, bit [30:0] tol);
    wait_idle();
    reg_write(REG_ROWS, rows);
    reg_write(REG_COLS, cols);
    reg_write(REG_COEF_X, kx);
    reg_write(REG_COEF_Y, ky);
    reg_write(REG_COEF_RHO, kr);
    reg_write(REG_SWEEP_LIMIT, maxit);
    reg_write(REG_TOL, {1'b0, tol});
    // every cell a sweep touches must hold a loaded value
    for (int i = 0; i < sb.eff_rows(); i++)
      for (int j = 0; j < sb.eff_cols(); j++)
        if (!written[i][j]) send(CMD_LOAD, i, j);
  endtask

  task automatic run_mix(int count);
    int er, ec, pick;
    er = sb.eff_rows();
    ec = sb.eff_cols();
    no_gaps = 0;
    for (int k = 0; k < count; k++) begin
      if (k % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send(CMD_SOLVE, $urandom_range(0, 63), $urandom_range(0, 63));
      end else if (pick < 10) begin
        send(2'd3, $urandom_range(0, 63), $urandom_range(0, 63));
      end else if (pick < 20 && (er < 64 || ec < 64)) begin
        // out of grid, load or read
        if (er < 64 && (ec == 64 || $urandom_range(0, 1)))
          send(pick < 15 ? CMD_LOAD : CMD_READ, $urandom_range(er, 63), $urandom_range(0, 63));
        else
          send(pick < 15 ? CMD_LOAD : CMD_READ, $urandom_range(0, 63), $urandom_range(ec, 63));
      end else if (pick < 60 && er > 0 && ec > 0) begin
        send(CMD_LOAD, $urandom_range(0, er - 1), $urandom_range(0, ec - 1));
      end else if (er > 0 && ec > 0) begin
        send(CMD_READ, $urandom_range(0, er - 1), $urandom_range(0, ec - 1));
      end else begin
        send(CMD_SOLVE, 0, 0);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: corners at the reset grid size, unused command
    send(CMD_LOAD, 0, 0);
    send(CMD_LOAD, 63, 63);
    send(CMD_READ, 0, 0);
    send(CMD_READ, 63, 63);
    send(2'd3, 5, 5);
    configure(4, 4, 32'h40000000, 32'h40000000, 32'h01000000, 50, 31'h100);
    send(CMD_SOLVE, 0, 0);
    send(CMD_READ, 1, 1);
    send(CMD_READ, 2, 2);
    send(CMD_LOAD, 4, 0);
    send(CMD_READ, 0, 4);
    send(2'd3, 63, 63);
    send(CMD_LOAD, 1, 2);
    send(CMD_SOLVE, 0, 0);
    send(CMD_READ, 1, 2);

    configure(5, 6, 32'h40000000, 32'h40000000, 32'h01000000, 40, 31'h1000);
    run_mix(300);
    configure(3, 3, 32'h80000000, 32'h7fffffff, 32'h10000000, 65535, 31'h10);
    run_mix(120);
    configure(2, 7, 32'h12345678, 32'h40000000, 32'h01000000, 9, 31'h0);
    run_mix(80);
    configure(0, 0, 0, 0, 0, 3, 31'h7fffffff);
    run_mix(40);
    configure(127, 3, $urandom, $urandom, $urandom, 3, 31'($urandom));
    run_mix(150);
    configure(3, 64, 32'h40000000, 32'h40000000, 32'h00800000, 4, 31'h2000);
    run_mix(150);
    configure(8, 8, 32'hffffffff, 32'hffffffff, 32'hffffffff, 5, 31'h0);
    run_mix(150);
    // the sender holds off once until the block has answered everything
    wait_idle();
    configure(6, 5, 32'h40000000, 32'h40000000, 32'h01000000, 0, 31'h100);
    run_mix(80);
    configure(7, 4, 32'h3fffffff, 32'h40000001, 32'h02000000, 1, 31'h7fffffff);
    run_mix(100);
    for (int p = 0; p < 4; p++) begin
      configure($urandom_range(3, 10), $urandom_range(3, 10),
                $urandom >> $urandom_range(0, 3), $urandom >> $urandom_range(0, 3),
                $urandom >> $urandom_range(0, 8), $urandom_range(1, 20),
                31'($urandom >> $urandom_range(1, 20)));
      run_mix(150);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
